>>> rtl/b2r_pkg.sv
// Shared types, symbol codes and digit pattern tables for the Roman numeral encoder.
`default_nettype none
package b2r_pkg;

  localparam int ValueW  = 14;
  localparam int SymbolW = 3;
  localparam logic [ValueW-1:0] MaxValue = 14'd3999;

  localparam logic [SymbolW-1:0] SYM_I = 3'd0;
  localparam logic [SymbolW-1:0] SYM_V = 3'd1;
  localparam logic [SymbolW-1:0] SYM_X = 3'd2;
  localparam logic [SymbolW-1:0] SYM_L = 3'd3;
  localparam logic [SymbolW-1:0] SYM_C = 3'd4;
  localparam logic [SymbolW-1:0] SYM_D = 3'd5;
  localparam logic [SymbolW-1:0] SYM_M = 3'd6;

  // Decade slots: the one, five and ten symbol of a decade.
  localparam logic [1:0] SLOT_ONE  = 2'd0;
  localparam logic [1:0] SLOT_FIVE = 2'd1;
  localparam logic [1:0] SLOT_TEN  = 2'd2;

  // Decade order in the entry: thousands first, units last.
  localparam logic [1:0] DEC_TH = 2'd0;
  localparam logic [1:0] DEC_HU = 2'd1;
  localparam logic [1:0] DEC_TE = 2'd2;
  localparam logic [1:0] DEC_UN = 2'd3;

  // One classified number, as the front hands it to the back.
  typedef struct packed {
    logic       err;
    logic [3:0] nz;   // nonzero digit mask, bit 0 = thousands
    logic [1:0] th;
    logic [3:0] hu;
    logic [3:0] te;
    logic [3:0] un;
  } b2r_entry_t;

  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd0:    n = 3'd0;
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] digit_slot(input logic [3:0] d, input logic [1:0] p);
    logic [1:0] s;
    s = SLOT_ONE;
    case (d)
      4'd4:    s = (p == 2'd1) ? SLOT_FIVE : SLOT_ONE;
      4'd5,
      4'd6,
      4'd7,
      4'd8:    s = (p == 2'd0) ? SLOT_FIVE : SLOT_ONE;
      4'd9:    s = (p == 2'd1) ? SLOT_TEN : SLOT_ONE;
      default: s = SLOT_ONE;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> rtl/b2r_front.sv
// Front end: range check and decimal digit split of each accepted number.
`default_nettype none
module b2r_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [b2r_pkg::ValueW-1:0] value,
  input  wire logic                      q_full,
  output logic                           push,
  output b2r_pkg::b2r_entry_t            push_entry
);
  import b2r_pkg::*;

  logic        s1_valid;
  logic        s1_err;
  logic [11:0] s1_v;
  logic [1:0]  s1_th;
  logic [5:0]  s1_q100;
  logic [8:0]  s1_q10;

  logic [24:0] p1000;
  logic [24:0] p100;
  logic [24:0] p10;
  logic        s1_en;
  logic        in_err;

  logic [5:0]  hu_w;
  logic [8:0]  te_w;
  logic [11:0] un_w;
  logic [3:0]  hu;
  logic [3:0]  te;
  logic [3:0]  un;

  // Reciprocal products, exact for values below 4096.
  assign p1000 = {13'd0, value[11:0]} * 25'd4195;
  assign p100  = {13'd0, value[11:0]} * 25'd5243;
  assign p10   = {13'd0, value[11:0]} * 25'd6554;
  assign in_err = (value == '0) || (value > MaxValue);

  assign push     = s1_valid && !q_full;
  assign in_stall = s1_valid && q_full;
  assign s1_en    = !s1_valid || !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_err  <= in_err;
      s1_v    <= value[11:0];
      s1_th   <= p1000[23:22];
      s1_q100 <= p100[24:19];
      s1_q10  <= p10[24:16];
    end
  end

  // Remainders of successive quotients give the digits.
  assign hu_w = s1_q100 - ({4'd0, s1_th} * 6'd10);
  assign te_w = s1_q10 - ({3'd0, s1_q100} * 9'd10);
  assign un_w = s1_v - ({3'd0, s1_q10} * 12'd10);
  assign hu = hu_w[3:0];
  assign te = te_w[3:0];
  assign un = un_w[3:0];

  always_comb begin
    push_entry.err = s1_err;
    push_entry.th  = s1_th;
    push_entry.hu  = hu;
    push_entry.te  = te;
    push_entry.un  = un;
    if (s1_err) begin
      push_entry.nz = 4'b0000;
    end else begin
      push_entry.nz = {un != 4'd0, te != 4'd0, hu != 4'd0, s1_th != 2'd0};
    end
  end

endmodule
`default_nettype wire

>>> rtl/b2r_queue.sv
// Short FIFO of classified numbers between front and back.
`default_nettype none
module b2r_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b2r_pkg::b2r_entry_t push_entry,
  output logic                     full,
  output logic                     q_valid,
  output b2r_pkg::b2r_entry_t      head,
  input  wire logic                pop
);
  import b2r_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  b2r_entry_t          mem [DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;

  assign full    = (count == CntW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/b2r_back.sv
// Back end: walks the head entry digits, one symbol per cycle unless stalled.
`default_nettype none
module b2r_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_valid,
  input  wire b2r_pkg::b2r_entry_t        head,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [b2r_pkg::SymbolW-1:0]     symbol,
  output logic                            range_error,
  output logic                            last_symbol
);
  import b2r_pkg::*;

  logic [3:0] done;
  logic [1:0] pos;

  logic [3:0]         rem;
  logic [1:0]         cur;
  logic [3:0]         cur_bit;
  logic [3:0]         digit;
  logic [2:0]         len;
  logic [1:0]         slot;
  logic [SymbolW-1:0] base;
  logic [SymbolW-1:0] sym;
  logic               digit_end;
  logic               last;
  logic               fire;

  assign rem = head.nz & ~done;

  always_comb begin
    if (rem[0]) begin
      cur = DEC_TH;
    end else if (rem[1]) begin
      cur = DEC_HU;
    end else if (rem[2]) begin
      cur = DEC_TE;
    end else begin
      cur = DEC_UN;
    end
  end

  assign cur_bit = 4'b0001 << cur;

  always_comb begin
    case (cur)
      DEC_TH:  begin digit = {2'b00, head.th}; base = SYM_M; end
      DEC_HU:  begin digit = head.hu;          base = SYM_C; end
      DEC_TE:  begin digit = head.te;          base = SYM_X; end
      DEC_UN:  begin digit = head.un;          base = SYM_I; end
      default: begin digit = head.un;          base = SYM_I; end
    endcase
  end

  assign len  = digit_len(digit);
  assign slot = digit_slot(digit, pos);
  // Thousands only ever use the one slot, so M needs no wrap.
  assign sym  = head.err ? SYM_I : base + {1'b0, slot};

  assign digit_end = ({1'b0, pos} == len - 3'd1);
  assign last      = head.err || (digit_end && ((rem & ~cur_bit) == 4'b0000));

  assign fire = q_valid && (!out_valid || !out_stall);
  assign pop  = fire && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 4'b0000;
      pos  <= 2'd0;
    end else if (fire) begin
      if (last) begin
        done <= 4'b0000;
        pos  <= 2'd0;
      end else if (digit_end) begin
        done <= done | cur_bit;
        pos  <= 2'd0;
      end else begin
        pos <= pos + 2'd1;
      end
    end
  end

  // Output register: load a new symbol whenever the last one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      symbol      <= sym;
      range_error <= head.err;
      last_symbol <= last;
    end
  end

endmodule
`default_nettype wire

>>> rtl/binary_to_roman_numeral_core.sv
// Top level of the binary to Roman numeral encoder.
// Each accepted 14-bit number comes out as its Roman numeral, one symbol
// transaction per cycle while out_stall is low (0=I 1=V 2=X 3=L 4=C 5=D
// 6=M), with last_symbol on the final one. Zero and values above 3999 give
// a single transaction with range_error and last_symbol set. A numeral has
// 1 to 15 symbols (3888 is the longest). Input numbers are taken one per
// cycle while the queue of QUEUE_DEPTH classified numbers has room; the
// first symbol reaches the output through the front register, a queue
// entry and the output register.
`default_nettype none
module binary_to_roman_numeral_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [b2r_pkg::ValueW-1:0]  value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [b2r_pkg::SymbolW-1:0]      symbol,
  output logic                             range_error,
  output logic                             last_symbol
);
  import b2r_pkg::*;

  logic       push;
  b2r_entry_t push_entry;
  logic       q_full;
  logic       q_valid;
  b2r_entry_t head;
  logic       pop;

  b2r_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop)
  );

  b2r_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .range_error (range_error),
    .last_symbol (last_symbol)
  );

endmodule
`default_nettype wire

>>> rtl/b2r_checker.sv
// Port-level checker for the Roman numeral encoder, bound to the top level.
`default_nettype none
module b2r_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [b2r_pkg::ValueW-1:0]  value,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [b2r_pkg::SymbolW-1:0] symbol,
  input wire logic                        range_error,
  input wire logic                        last_symbol
);
  import b2r_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && !in_stall && (value != '0);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(symbol) && $stable(range_error) && $stable(last_symbol))
    else $error("output payload changed while stalled");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last_symbol)
    else $error("range error transaction not marked last");

  a_sym_code: assert property (@(posedge clk) disable iff (rst || !in_seen && in_seen)
    out_valid && !range_error |-> symbol <= SYM_M)
    else $error("symbol code out of range");

endmodule

bind binary_to_roman_numeral_core b2r_checker u_b2r_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .value       (value),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .symbol      (symbol),
  .range_error (range_error),
  .last_symbol (last_symbol)
);
`default_nettype wire

>>> dv/tb_binary_to_roman_numeral_core.sv
// Self-checking testbench for the binary to Roman numeral encoder core.
`timescale 1ns / 1ps
module tb_binary_to_roman_numeral_core;
  import b2r_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 8;

  typedef struct packed {
    logic [ValueW-1:0]  source;
    logic [SymbolW-1:0] symbol;
    logic               range_error;
    logic               last_symbol;
  } numeral_sym_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  wire logic           in_stall;
  logic [ValueW-1:0]   value = '0;
  wire logic           out_valid;
  logic                out_stall = 1'b0;
  wire logic [SymbolW-1:0] symbol;
  wire logic           range_error;
  wire logic           last_symbol;

  numeral_sym_t numeral_q[$];
  numeral_sym_t got;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  free_left = 0;
  bit  no_idle = 1'b0;

  binary_to_roman_numeral_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .symbol     (symbol),
    .range_error(range_error),
    .last_symbol(last_symbol)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Expected numeral for one number, queued symbol by symbol.
  function automatic void predict_numeral(input logic [ValueW-1:0] v);
    logic [SymbolW-1:0] syms [0:14];
    logic [SymbolW-1:0] one_sym [0:3];
    logic [SymbolW-1:0] five_sym [0:3];
    logic [SymbolW-1:0] ten_sym [0:3];
    int digits [0:3];
    int n;
    int d;
    int k;
    int num;
    numeral_sym_t e;
    num = v;
    e.source = v;
    if (num == 0 || num > MaxValue) begin
      e.symbol = SYM_I;
      e.range_error = 1'b1;
      e.last_symbol = 1'b1;
      numeral_q.push_back(e);
      return;
    end
    one_sym[0] = SYM_M; five_sym[0] = SYM_M; ten_sym[0] = SYM_M;
    one_sym[1] = SYM_C; five_sym[1] = SYM_D; ten_sym[1] = SYM_M;
    one_sym[2] = SYM_X; five_sym[2] = SYM_L; ten_sym[2] = SYM_C;
    one_sym[3] = SYM_I; five_sym[3] = SYM_V; ten_sym[3] = SYM_X;
    digits[0] = num / 1000;
    digits[1] = (num / 100) % 10;
    digits[2] = (num / 10) % 10;
    digits[3] = num % 10;
    n = 0;
    for (int dec = 0; dec < 4; dec++) begin
      d = digits[dec];
      case (d)
        1, 2, 3: begin
          for (k = 0; k < d; k++) begin
            syms[n] = one_sym[dec];
            n++;
          end
        end
        4: begin
          syms[n] = one_sym[dec];
          syms[n+1] = five_sym[dec];
          n += 2;
        end
        5, 6, 7, 8: begin
          syms[n] = five_sym[dec];
          n++;
          for (k = 5; k < d; k++) begin
            syms[n] = one_sym[dec];
            n++;
          end
        end
        9: begin
          syms[n] = one_sym[dec];
          syms[n+1] = ten_sym[dec];
          n += 2;
        end
        default: ;
      endcase
    end
    for (k = 0; k < n; k++) begin
      e.symbol = syms[k];
      e.range_error = 1'b0;
      e.last_symbol = (k == n - 1);
      numeral_q.push_back(e);
    end
  endfunction

  // Present one number, hold it until accepted, then maybe idle.
  task automatic send_value(input logic [ValueW-1:0] v);
    int gap;
    value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_numeral(v);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (numeral_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [ValueW-1:0] random_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return ValueW'($urandom_range(1, MaxValue));
    if (r < 90) return ValueW'($urandom_range(MaxValue + 1, (1 << ValueW) - 1));
    if (r < 95) return '0;
    return ValueW'($urandom_range(0, (1 << ValueW) - 1));
  endfunction

  // Output side stalls in bursts with free stretches in between.
  always @(posedge clk) begin
    if (rst || no_idle) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left <= free_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_gap();
      free_left <= $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (numeral_q.size() == 0) begin
        $display("%0t: unexpected transaction: symbol %0d range_error %0b last_symbol %0b",
                 $time, symbol, range_error, last_symbol);
        fail_count++;
      end else begin
        got = numeral_q.pop_front();
        if (symbol !== got.symbol) begin
          $display("%0t: value %0d symbol mismatch: expected %0d actual %0d",
                   $time, got.source, got.symbol, symbol);
          fail_count++;
        end
        if (range_error !== got.range_error) begin
          $display("%0t: value %0d range_error mismatch: expected %0b actual %0b",
                   $time, got.source, got.range_error, range_error);
          fail_count++;
        end
        if (last_symbol !== got.last_symbol) begin
          $display("%0t: value %0d last_symbol mismatch: expected %0b actual %0b",
                   $time, got.source, got.last_symbol, last_symbol);
          fail_count++;
        end
      end
    end
  end

  task automatic test_range_limits();
    send_value(14'd0);
    send_value(14'd1);
    send_value(14'd3999);
    send_value(14'd4000);
    send_value(14'd16383);
    send_value(14'd3888);
    send_value(14'd3000);
  endtask

  task automatic test_digit_patterns();
    send_value(14'd4);
    send_value(14'd9);
    send_value(14'd5);
    send_value(14'd40);
    send_value(14'd90);
    send_value(14'd50);
    send_value(14'd400);
    send_value(14'd900);
    send_value(14'd500);
    send_value(14'd444);
    send_value(14'd999);
    send_value(14'd1994);
    send_value(14'd2008);
    send_value(14'd3449);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (20) send_value(random_value());
    no_idle = 1'b0;
  endtask

  task automatic test_pause_until_drained();
    repeat (5) send_value(random_value());
    wait_drained();
    repeat (5) send_value(random_value());
  endtask

  task automatic test_random_values();
    repeat (50) send_value(random_value());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_range_limits();
    test_digit_patterns();
    test_back_to_back();
    test_pause_until_drained();
    test_random_values();
    wait_drained();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/b2r_pkg.sv
rtl/b2r_front.sv
rtl/b2r_queue.sv
rtl/b2r_back.sv
rtl/binary_to_roman_numeral_core.sv
rtl/b2r_checker.sv
dv/tb_binary_to_roman_numeral_core.sv
